@@ sv/ubx_frame_deframer_core_defines.svh @@
// Assertion macros for the deframer RTL.
`ifndef UBX_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define UBX_FRAME_DEFRAMER_CORE_DEFINES_SVH

`ifndef SYNTH

// Checks that a condition holds at every clock edge outside reset.
`define UBXFD_ASSERT(name, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("deframer check failed");

// Checks that a condition implies another one at the next clock edge.
`define UBXFD_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("deframer sequence check failed");

`else

`define UBXFD_ASSERT(name, expr)
`define UBXFD_ASSERT_NEXT(name, pre, post)

`endif

`endif

@@ sv/ubxfd_pkg.sv @@
// Types and constants shared by the frame deframer modules.
package ubxfd_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  localparam logic [15:0] MAX_LEN_RESET = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_OK       = 2'd1,
    KIND_BAD_SUM  = 2'd2,
    KIND_TOO_LONG = 2'd3
  } kind_t;

  typedef enum logic [8:0] {
    PH_HUNT1   = 9'b000000001,
    PH_HUNT2   = 9'b000000010,
    PH_CLASS   = 9'b000000100,
    PH_ID      = 9'b000001000,
    PH_LEN_LO  = 9'b000010000,
    PH_LEN_HI  = 9'b000100000,
    PH_PAYLOAD = 9'b001000000,
    PH_CK_A    = 9'b010000000,
    PH_CK_B    = 9'b100000000
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  class_id;
    logic [7:0]  message_id;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic        last;
    logic [15:0] frame_length;
  } result_t;

endpackage

@@ sv/ubxfd_parser.sv @@
// Frame parser: sync hunt, header capture, payload indexing and checksum sums.
module ubxfd_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           rx_byte,
  input  logic [15:0]          max_payload_length,
  output logic                 res_valid,
  output ubxfd_pkg::result_t   res
);

  ubxfd_pkg::phase_t phase, phase_next;
  logic [7:0]  frame_class, frame_class_next;
  logic [7:0]  frame_msg_id, frame_msg_id_next;
  logic [15:0] payload_length, payload_length_next;
  logic [15:0] payload_count, payload_count_next;
  logic [7:0]  sum_a, sum_a_next;
  logic [7:0]  sum_b, sum_b_next;
  logic [7:0]  check_a, check_a_next;

  logic [15:0] len_full;
  logic [16:0] count_plus;
  logic        is_last;
  logic [7:0]  add_a;

  assign len_full   = {rx_byte, payload_length[7:0]};
  assign count_plus = {1'b0, payload_count} + 17'd1;
  assign is_last    = count_plus >= {1'b0, payload_length};
  assign add_a      = sum_a + rx_byte;

  always_comb begin
    phase_next          = phase;
    frame_class_next    = frame_class;
    frame_msg_id_next   = frame_msg_id;
    payload_length_next = payload_length;
    payload_count_next  = payload_count;
    sum_a_next          = sum_a;
    sum_b_next          = sum_b;
    check_a_next        = check_a;
    res_valid           = 1'b0;
    res.kind            = ubxfd_pkg::KIND_DATA;
    res.class_id        = frame_class;
    res.message_id      = frame_msg_id;
    res.data_byte       = 8'd0;
    res.byte_index      = 16'd0;
    res.last            = 1'b0;
    res.frame_length    = payload_length;

    case (phase)
      ubxfd_pkg::PH_HUNT1: begin
        if (rx_byte == ubxfd_pkg::SYNC_FIRST) begin
          phase_next = ubxfd_pkg::PH_HUNT2;
        end
      end
      ubxfd_pkg::PH_HUNT2: begin
        if (rx_byte == ubxfd_pkg::SYNC_SECOND) begin
          phase_next = ubxfd_pkg::PH_CLASS;
        end else if (rx_byte != ubxfd_pkg::SYNC_FIRST) begin
          phase_next = ubxfd_pkg::PH_HUNT1;
        end
      end
      ubxfd_pkg::PH_CLASS: begin
        // Sums restart here, so both start from the class byte itself.
        sum_a_next       = rx_byte;
        sum_b_next       = rx_byte;
        frame_class_next = rx_byte;
        phase_next       = ubxfd_pkg::PH_ID;
      end
      ubxfd_pkg::PH_ID: begin
        sum_a_next        = add_a;
        sum_b_next        = sum_b + add_a;
        frame_msg_id_next = rx_byte;
        phase_next        = ubxfd_pkg::PH_LEN_LO;
      end
      ubxfd_pkg::PH_LEN_LO: begin
        sum_a_next          = add_a;
        sum_b_next          = sum_b + add_a;
        payload_length_next = {8'd0, rx_byte};
        phase_next          = ubxfd_pkg::PH_LEN_HI;
      end
      ubxfd_pkg::PH_LEN_HI: begin
        sum_a_next          = add_a;
        sum_b_next          = sum_b + add_a;
        payload_length_next = len_full;
        payload_count_next  = 16'd0;
        if (len_full > max_payload_length) begin
          res_valid        = 1'b1;
          res.kind         = ubxfd_pkg::KIND_TOO_LONG;
          res.frame_length = len_full;
          phase_next       = ubxfd_pkg::PH_HUNT1;
        end else if (len_full == 16'd0) begin
          phase_next = ubxfd_pkg::PH_CK_A;
        end else begin
          phase_next = ubxfd_pkg::PH_PAYLOAD;
        end
      end
      ubxfd_pkg::PH_PAYLOAD: begin
        sum_a_next         = add_a;
        sum_b_next         = sum_b + add_a;
        res_valid          = 1'b1;
        res.data_byte      = rx_byte;
        res.byte_index     = payload_count;
        res.last           = is_last;
        payload_count_next = count_plus[15:0];
        if (is_last) begin
          phase_next = ubxfd_pkg::PH_CK_A;
        end
      end
      ubxfd_pkg::PH_CK_A: begin
        check_a_next = rx_byte;
        phase_next   = ubxfd_pkg::PH_CK_B;
      end
      ubxfd_pkg::PH_CK_B: begin
        res_valid  = 1'b1;
        res.kind   = ((check_a == sum_a) && (rx_byte == sum_b)) ?
                     ubxfd_pkg::KIND_OK : ubxfd_pkg::KIND_BAD_SUM;
        phase_next = ubxfd_pkg::PH_HUNT1;
      end
      default: begin
        phase_next = ubxfd_pkg::PH_HUNT1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= ubxfd_pkg::PH_HUNT1;
      frame_class    <= 8'd0;
      frame_msg_id   <= 8'd0;
      payload_length <= 16'd0;
      payload_count  <= 16'd0;
      sum_a          <= 8'd0;
      sum_b          <= 8'd0;
      check_a        <= 8'd0;
    end else if (step) begin
      phase          <= phase_next;
      frame_class    <= frame_class_next;
      frame_msg_id   <= frame_msg_id_next;
      payload_length <= payload_length_next;
      payload_count  <= payload_count_next;
      sum_a          <= sum_a_next;
      sum_b          <= sum_b_next;
      check_a        <= check_a_next;
    end
  end

endmodule

@@ sv/ubx_frame_deframer_core.sv @@
// Top level of the frame deframer: stream ports, output skid stage, config register.
//
//  channel   direction  ports                          payload
//  s_*       in         s_tvalid s_tready s_tdata      rx_byte
//  m_*       out        m_tvalid m_tready m_tdata ...  one result per payload/status
//  apb       in/out     psel penable pwrite paddr ...  max_payload_length at 0x0
//
// One byte is taken per cycle while s_tready is high; any result it yields is registered to m_tdata.
// The parser updates its state in the cycle a byte is accepted, and the result
// lands in an output register backed by a one-entry skid register.
// s_tready drops only while the skid register holds a result.
// Reset is synchronous and returns the parser to the sync hunt.
`include "ubx_frame_deframer_core_defines.svh"

module ubx_frame_deframer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // class_id, message_id, data_byte, byte_index, frame_length (lowest bit up)
  output logic [55:0] m_tdata,
  output logic        m_tlast,   // last
  output logic [1:0]  m_tuser,   // kind
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] max_payload_length;
  logic        reg_hit;
  logic        in_take;
  logic        out_take;
  logic        res_valid;
  logic        res_push;
  ubxfd_pkg::result_t res;
  ubxfd_pkg::result_t out_res;
  ubxfd_pkg::result_t skid_res;
  logic        out_valid;
  logic        skid_valid;

  // Configuration register.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == 1'b0);
  assign prdata  = reg_hit ? {16'd0, max_payload_length} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_length <= ubxfd_pkg::MAX_LEN_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      max_payload_length <= pwdata[15:0];
    end
  end

  assign s_tready = !skid_valid;
  assign in_take  = s_tvalid && s_tready;

  ubxfd_parser u_parser (
    .clk                (clk),
    .rst                (rst),
    .step               (in_take),
    .rx_byte            (s_tdata),
    .max_payload_length (max_payload_length),
    .res_valid          (res_valid),
    .res                (res)
  );

  assign res_push = in_take && res_valid;
  assign out_take = out_valid && m_tready;

  // The output register refills from the skid register first; a new result
  // goes to the skid register only while the output register is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || out_take) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= res_push;
        end
      end else if (res_push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (res_push) begin
        out_res <= res;
      end
    end else if (res_push) begin
      skid_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.kind;
  assign m_tlast  = out_res.last;
  assign m_tdata  = {out_res.frame_length, out_res.byte_index, out_res.data_byte,
                     out_res.message_id, out_res.class_id};

  `UBXFD_ASSERT(a_skid_behind_out, !skid_valid || out_valid)
  `UBXFD_ASSERT(a_status_fields_zero, !(out_valid && (out_res.kind != ubxfd_pkg::KIND_DATA)) || ((out_res.data_byte == 8'd0) && (out_res.byte_index == 16'd0) && !out_res.last))
  `UBXFD_ASSERT(a_last_index, !(out_valid && out_res.last) || (({1'b0, out_res.byte_index} + 17'd1) == {1'b0, out_res.frame_length}))
  `UBXFD_ASSERT_NEXT(a_skid_drains, skid_valid && m_tready, !skid_valid)

endmodule
